### hdl/cop_pkg.sv
// Shared constants and types for the circle octant point generator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package cop_pkg;

  // Fixed width of the two's complement point coordinates.
  localparam int OUT_BITS = 14;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_CENTER_X = 2'd1,
    REG_CENTER_Y = 2'd2
  } reg_index_t;

  // Queue occupancy flags seen by both sides of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### hdl/cop_front.sv
// Front part: accepts column offsets, sorts them into no-point, axis and octant
// requests, and computes the rounded square root for octant requests. Uses cop_pkg.
module cop_front #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic [RADIUS_BITS-1:0] column_offset,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  cop_pkg::qstat_t        qstat,
  output logic                   push,
  output logic [RADIUS_BITS-1:0] ent_x,
  output logic [RADIUS_BITS-1:0] ent_y,
  output logic                   ent_axis
);
  import cop_pkg::*;

  localparam int RB    = RADIUS_BITS;
  localparam int PB    = RB + (RB % 2);
  localparam int NB    = 2 * PB;
  localparam int RW    = PB + 2;
  localparam int ITERS = PB / 2;
  localparam int CW    = $clog2(ITERS);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIFF = 4'b0010,
    F_ROOT = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t         state;
  logic [RB-1:0]   x_q;
  logic [2*RB-1:0] rr;
  logic [2*RB-1:0] xx;
  logic [NB-1:0]   nrem;
  logic [RW-1:0]   rem;
  logic [PB-1:0]   root;
  logic [CW-1:0]   cnt;

  logic            accept;
  logic [RW-1:0]   rem_next;
  logic [PB-1:0]   root_next;
  logic [NB-1:0]   nrem_next;
  logic [RW-1:0]   shifted;
  logic [RW-1:0]   trial;
  logic [PB-1:0]   root_inc;
  logic [RB-1:0]   y_round;

  assign push     = (state == F_PUSH) && !qstat.full;
  assign in_stall = !((state == F_IDLE) || push);
  assign accept   = in_valid && !in_stall;

  // Two result bits per cycle of the digit-by-digit square root.
  always_comb begin
    rem_next  = rem;
    root_next = root;
    nrem_next = nrem;
    shifted   = '0;
    trial     = '0;
    for (int k = 0; k < 2; k++) begin
      shifted   = {rem_next[RW-3:0], nrem_next[NB-1 -: 2]};
      trial     = {root_next, 2'b01};
      nrem_next = {nrem_next[NB-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_next  = shifted - trial;
        root_next = {root_next[PB-2:0], 1'b1};
      end else begin
        rem_next  = shifted;
        root_next = {root_next[PB-2:0], 1'b0};
      end
    end
  end

  // The final remainder is n - root^2; round up when it exceeds the root.
  assign root_inc = root_next + PB'(1);
  assign y_round  = (rem_next > RW'(root_next)) ? RB'(root_inc) : RB'(root_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE, F_PUSH: begin
          if (accept) begin
            if (column_offset >= radius) begin
              state <= F_IDLE;
            end else if (column_offset == '0) begin
              state <= F_PUSH;
            end else begin
              state <= F_DIFF;
            end
          end else if (push) begin
            state <= F_IDLE;
          end
        end
        F_DIFF: begin
          state <= F_ROOT;
        end
        F_ROOT: begin
          if (cnt == '0) begin
            state <= F_PUSH;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q      <= column_offset;
      rr       <= radius * radius;
      xx       <= column_offset * column_offset;
      ent_x    <= '0;
      ent_y    <= radius;
      ent_axis <= 1'b1;
    end
    if (state == F_DIFF) begin
      nrem <= NB'(rr - xx);
      rem  <= '0;
      root <= '0;
      cnt  <= CW'(ITERS - 1);
    end
    if (state == F_ROOT) begin
      nrem <= nrem_next;
      rem  <= rem_next;
      root <= root_next;
      cnt  <= cnt - CW'(1);
      if (cnt == '0) begin
        ent_x    <= x_q;
        ent_y    <= y_round;
        ent_axis <= 1'b0;
      end
    end
  end

  // An octant offset under work is always inside the circle.
  a_root_inside: assert property (@(posedge clk) disable iff (rst)
    (state == F_ROOT) |-> (x_q < radius))
    else $error("offset under root computation is not below the radius");

  // A rounded root never exceeds the radius.
  a_push_range: assert property (@(posedge clk) disable iff (rst)
    push |-> (ent_y <= radius))
    else $error("queued root exceeds the radius");

  // Nothing is pushed or accepted while the front is busy with a root.
  a_root_no_push: assert property (@(posedge clk) disable iff (rst)
    ((state == F_DIFF) || (state == F_ROOT)) |-> (!push && in_stall))
    else $error("front pushed or accepted during root computation");

endmodule

### hdl/cop_queue.sv
// Two-entry queue between the front and back parts, holding offset, root and
// the axis flag of each request. Uses cop_pkg for the status struct.
module cop_queue #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [RADIUS_BITS-1:0] wr_x,
  input  logic [RADIUS_BITS-1:0] wr_y,
  input  logic                   wr_axis,
  input  logic                   pop,
  output logic [RADIUS_BITS-1:0] rd_x,
  output logic [RADIUS_BITS-1:0] rd_y,
  output logic                   rd_axis,
  output cop_pkg::qstat_t        qstat
);
  import cop_pkg::*;

  localparam int DEPTH = 2;

  logic [RADIUS_BITS-1:0] q_x    [DEPTH];
  logic [RADIUS_BITS-1:0] q_y    [DEPTH];
  logic                   q_axis [DEPTH];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;

  assign qstat.full  = (count == 2'(DEPTH));
  assign qstat.empty = (count == 2'd0);
  assign rd_x        = q_x[rd_ptr];
  assign rd_y        = q_y[rd_ptr];
  assign rd_axis     = q_axis[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_x[wr_ptr]    <= wr_x;
      q_y[wr_ptr]    <= wr_y;
      q_axis[wr_ptr] <= wr_axis;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!qstat.full || pop))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("request popped from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue count out of range");

endmodule

### hdl/cop_back.sv
// Back part: takes one request at a time from the queue and emits its four or
// eight symmetric points through an output register. Uses cop_pkg.
module cop_back #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [COORD_BITS-1:0]              center_x,
  input  logic [COORD_BITS-1:0]              center_y,
  input  cop_pkg::qstat_t                    qstat,
  input  logic [RADIUS_BITS-1:0]             rd_x,
  input  logic [RADIUS_BITS-1:0]             rd_y,
  input  logic                               rd_axis,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cop_pkg::OUT_BITS-1:0] point_x,
  output logic signed [cop_pkg::OUT_BITS-1:0] point_y,
  output logic                               last_point
);
  import cop_pkg::*;

  // Bit 2 swaps the roles of offset and root, bit 1 negates the horizontal
  // term and bit 0 negates the vertical term.
  typedef enum logic [2:0] {
    PT_PX_PY = 3'd0,
    PT_PX_MY = 3'd1,
    PT_MX_PY = 3'd2,
    PT_MX_MY = 3'd3,
    PT_PY_PX = 3'd4,
    PT_PY_MX = 3'd5,
    PT_MY_PX = 3'd6,
    PT_MY_MX = 3'd7
  } point_t;

  logic                 busy;
  logic [RADIUS_BITS-1:0] cur_x;
  logic [RADIUS_BITS-1:0] cur_y;
  logic                 cur_axis;
  point_t               idx;
  point_t               idx_next;

  logic                 slot_free;
  logic                 emit;
  logic                 is_last;
  logic [OUT_BITS-1:0]  cx;
  logic [OUT_BITS-1:0]  cy;
  logic [OUT_BITS-1:0]  u;
  logic [OUT_BITS-1:0]  v;
  logic [OUT_BITS-1:0]  px;
  logic [OUT_BITS-1:0]  py;
  logic [2:0]           code;

  assign slot_free = !out_valid || !out_stall;
  assign emit      = busy && slot_free;
  assign is_last   = cur_axis ? (idx == PT_MY_PX) : (idx == PT_MY_MX);
  assign pop       = !qstat.empty && (!busy || (emit && is_last));

  assign code = idx;
  assign cx   = OUT_BITS'(center_x);
  assign cy   = OUT_BITS'(center_y);
  assign u    = code[2] ? OUT_BITS'(cur_y) : OUT_BITS'(cur_x);
  assign v    = code[2] ? OUT_BITS'(cur_x) : OUT_BITS'(cur_y);
  assign px   = code[1] ? (cx - u) : (cx + u);
  assign py   = code[0] ? (cy - v) : (cy + v);

  // Axis requests visit only the four points that are distinct when x is zero.
  always_comb begin
    unique case (idx)
      PT_PX_PY: idx_next = PT_PX_MY;
      PT_PX_MY: idx_next = cur_axis ? PT_PY_PX : PT_MX_PY;
      PT_MX_PY: idx_next = PT_MX_MY;
      PT_MX_MY: idx_next = PT_PY_PX;
      PT_PY_PX: idx_next = cur_axis ? PT_MY_PX : PT_PY_MX;
      PT_PY_MX: idx_next = PT_MY_PX;
      PT_MY_PX: idx_next = PT_MY_MX;
      PT_MY_MX: idx_next = PT_PX_PY;
      default:  idx_next = PT_PX_PY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= PT_PX_PY;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (slot_free) begin
        out_valid <= 1'b0;
      end
      // A new request taken on the last point of the current one starts at once.
      if (pop) begin
        busy <= 1'b1;
        idx  <= PT_PX_PY;
      end else if (emit) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      point_x    <= px;
      point_y    <= py;
      last_point <= is_last;
    end
    if (pop) begin
      cur_x    <= rd_x;
      cur_y    <= rd_y;
      cur_axis <= rd_axis;
    end
  end

  a_axis_points: assert property (@(posedge clk) disable iff (rst)
    (busy && cur_axis) |->
      (idx == PT_PX_PY || idx == PT_PX_MY || idx == PT_PY_PX || idx == PT_MY_PX))
    else $error("axis request reached a point it does not have");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted point not presented");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    (pop && busy) |-> (emit && is_last))
    else $error("new request taken before the current one finished");

endmodule

### hdl/circle_octant_point_generator_core.sv
// Circle octant point generator: one column offset in, up to eight points out.
// Points leave at one point per cycle while out_stall is low: eight per octant
// offset, four per axis offset. The front takes no new offset while it is busy
// with a root, and can take the next one as it pushes the current request.
// Reset (rst, synchronous) empties the queue and clears radius and center to zero.
module circle_octant_point_generator_core #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [((RADIUS_BITS > COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [RADIUS_BITS-1:0]              column_offset,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cop_pkg::OUT_BITS-1:0] point_x,
  output logic signed [cop_pkg::OUT_BITS-1:0] point_y,
  output logic                                last_point
);
  import cop_pkg::*;

  logic [RADIUS_BITS-1:0] radius;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;

  qstat_t                 qstat;
  logic                   push;
  logic                   pop;
  logic [RADIUS_BITS-1:0] ent_x;
  logic [RADIUS_BITS-1:0] ent_y;
  logic                   ent_axis;
  logic [RADIUS_BITS-1:0] rd_x;
  logic [RADIUS_BITS-1:0] rd_y;
  logic                   rd_axis;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= '0;
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS:   radius   <= RADIUS_BITS'(cfg_data);
        REG_CENTER_X: center_x <= COORD_BITS'(cfg_data);
        REG_CENTER_Y: center_y <= COORD_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  cop_front #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .radius       (radius),
    .column_offset(column_offset),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .qstat        (qstat),
    .push         (push),
    .ent_x        (ent_x),
    .ent_y        (ent_y),
    .ent_axis     (ent_axis)
  );

  cop_queue #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_x   (ent_x),
    .wr_y   (ent_y),
    .wr_axis(ent_axis),
    .pop    (pop),
    .rd_x   (rd_x),
    .rd_y   (rd_y),
    .rd_axis(rd_axis),
    .qstat  (qstat)
  );

  cop_back #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .center_x  (center_x),
    .center_y  (center_y),
    .qstat     (qstat),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .rd_axis   (rd_axis),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .last_point(last_point)
  );

endmodule
